### rtl/linked_list_deque_engine_assert.svh
// assertion macros for the linked list deque engine
// no dependencies; included by files that carry concurrent checks
`ifndef LINKED_LIST_DEQUE_ENGINE_ASSERT_SVH
`define LINKED_LIST_DEQUE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lld_pkg.sv
// shared types and field widths of the linked list deque engine
// no dependencies
package lld_pkg;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int HANDLE_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT   = 3'd0,
        FN_PUSH_BACK    = 3'd1,
        FN_POP_FRONT    = 3'd2,
        FN_POP_BACK     = 3'd3,
        FN_INSERT_AFTER = 3'd4,
        FN_REMOVE       = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DEAD  = 2'd3
    } t_status;

    // write enables of the node memory fields
    typedef struct packed {
        logic value;
        logic live;
        logic next;
        logic prev;
    } t_node_we;

    typedef struct packed {
        t_status                    status;
        logic [HANDLE_W-1:0]        used_handle;
        logic signed [DATA_W-1:0]   removed_value;
        logic [COUNT_W-1:0]         entry_count;
    } t_result;

endpackage

### rtl/lld_ifs.sv
// request and response channel interfaces of the deque engine
// depends on lld_pkg for the field widths
interface lld_req_if import lld_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [DATA_W-1:0]   data_value;
    logic [HANDLE_W-1:0]        node_handle;

    modport source (output valid, output func, output data_value, output node_handle,
                    input ready);
    modport sink   (input valid, input func, input data_value, input node_handle,
                    output ready);
endinterface

interface lld_rsp_if import lld_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [HANDLE_W-1:0]        used_handle;
    logic signed [DATA_W-1:0]   removed_value;
    logic [COUNT_W-1:0]         entry_count;

    modport source (output valid, output status, output used_handle, output removed_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input used_handle, input removed_value,
                    input entry_count, output ready);
endinterface

### rtl/lld_node_mem.sv
// node pool memory: value, live flag, next and prev link per node
// one registered read port, one write port per field; uses lld_pkg
module lld_node_mem import lld_pkg::*; #(
    parameter int  POOL_NODES = 16,
    parameter int  VALUE_BITS = 32,
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1,
    localparam int IW = $clog2(POOL_NODES + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic signed [VALUE_BITS-1:0] o_rd_value,
    output logic                         o_rd_live,
    output logic [IW-1:0]                o_rd_next,
    output logic [IW-1:0]                o_rd_prev,
    input  t_node_we                     i_we,
    input  logic [AW-1:0]                i_value_addr,
    input  logic [AW-1:0]                i_live_addr,
    input  logic [AW-1:0]                i_next_addr,
    input  logic [AW-1:0]                i_prev_addr,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_live,
    input  logic [IW-1:0]                i_next,
    input  logic [IW-1:0]                i_prev
);

    logic signed [VALUE_BITS-1:0] r_value_mem [POOL_NODES];
    logic                         r_live_mem  [POOL_NODES];
    logic [IW-1:0]                r_next_mem  [POOL_NODES];
    logic [IW-1:0]                r_prev_mem  [POOL_NODES];

    always_ff @(posedge i_clk) begin
        if (i_we.value) begin
            r_value_mem[i_value_addr] <= i_value;
        end
        if (i_we.live) begin
            r_live_mem[i_live_addr] <= i_live;
        end
        if (i_we.next) begin
            r_next_mem[i_next_addr] <= i_next;
        end
        if (i_we.prev) begin
            r_prev_mem[i_prev_addr] <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_value <= r_value_mem[i_rd_addr];
            o_rd_live  <= r_live_mem[i_rd_addr];
            o_rd_next  <= r_next_mem[i_rd_addr];
            o_rd_prev  <= r_prev_mem[i_rd_addr];
        end
    end

endmodule

### rtl/lld_free_stack.sv
// free node stack in a memory with a low-water mark
// positions below the mark were never written and read as their own index
module lld_free_stack #(
    parameter int  POOL_NODES = 16,
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1,
    localparam int IW = $clog2(POOL_NODES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd,
    input  logic          i_pop,
    input  logic          i_push,
    input  logic [AW-1:0] i_push_idx,
    output logic [AW-1:0] o_idx,
    output logic [IW-1:0] o_top,
    output logic [IW-1:0] o_low
);

    logic [AW-1:0] r_stack [POOL_NODES];
    logic [AW-1:0] r_rdata;
    logic [AW-1:0] r_fresh_idx;
    logic          r_fresh;
    logic [IW-1:0] r_top;
    logic [IW-1:0] r_low;
    logic [IW-1:0] top_m1;

    assign top_m1 = r_top - IW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_stack[AW'(r_top)] <= i_push_idx;
        end
        if (i_rd) begin
            r_rdata     <= r_stack[AW'(top_m1)];
            r_fresh     <= (top_m1 < r_low);
            r_fresh_idx <= AW'(top_m1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= IW'(POOL_NODES);
            r_low <= IW'(POOL_NODES);
        end else if (i_pop) begin
            r_top <= top_m1;
            if (top_m1 < r_low) begin
                r_low <= top_m1;
            end
        end else if (i_push) begin
            r_top <= r_top + IW'(1);
        end
    end

    assign o_idx = r_fresh ? r_fresh_idx : r_rdata;
    assign o_top = r_top;
    assign o_low = r_low;

endmodule

### rtl/linked_list_deque_engine.sv
// channel      dir  fields                                        handshake
// i_req        in   func, data_value, node_handle                 valid/ready
// o_rsp        out  status, used_handle, removed_value, entry_count valid/ready
//
// pops, removes and rejected requests pass execute only, pushes and insert-after
// also a link state writing the neighbor links, since each link field of the node
// memory has one write port and a new node needs its own and its neighbors' links
// reset is synchronous and clears control only; no memory sweep is needed, the
// free stack low-water mark tells which nodes were ever handed out
// a stalled response parks in the output word, the next request is still taken
// depends on lld_pkg, lld_ifs, lld_node_mem, lld_free_stack and the assert header
`include "linked_list_deque_engine_assert.svh"

module linked_list_deque_engine import lld_pkg::*; #(
    parameter int POOL_NODES = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lld_req_if.sink    i_req,
    lld_rsp_if.source  o_rsp
);

    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int IW = $clog2(POOL_NODES + 1);
    localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LINK = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    t_func                        r_func;
    logic signed [VALUE_BITS-1:0] r_dv;
    logic [AW-1:0]                r_h;
    logic                         r_h_ok;
    logic [AW-1:0]                r_tgt;
    logic [IW-1:0]                r_first, n_first;
    logic [IW-1:0]                r_last, n_last;
    logic [IW-1:0]                r_count, n_count;
    logic [IW-1:0]                r_lnk_p, r_lnk_q;
    logic [AW-1:0]                r_k;
    t_result                      r_res, res_c;
    t_result                      r_out, n_out;
    logic                         r_out_valid, n_out_valid;

    logic                         accept;
    logic                         slot_free;
    logic [AW-1:0]                rd_addr;
    logic                         in_pool;

    logic signed [VALUE_BITS-1:0] rd_value;
    logic                         rd_live;
    logic [IW-1:0]                rd_next, rd_prev;
    t_node_we                     we;
    logic [AW-1:0]                value_addr, live_addr, next_addr, prev_addr;
    logic                         live_wd;
    logic [IW-1:0]                next_wd, prev_wd;

    logic                         fs_pop, fs_push;
    logic [AW-1:0]                fs_idx;
    logic [IW-1:0]                fs_top, fs_low;

    t_status                      exe_status;
    logic                         do_alloc, do_unlink;
    logic [IW-1:0]                alloc_prev, alloc_next;
    logic                         full, h_live, pop_nil;
    logic [IW-1:0]                k_ext;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign in_pool     = 32'(i_req.node_handle) < 32'(POOL_NODES);

    always_comb begin
        unique case (t_func'(i_req.func))
            FN_POP_FRONT: rd_addr = AW'(r_first);
            FN_POP_BACK:  rd_addr = AW'(r_last);
            default:      rd_addr = AW'(i_req.node_handle);
        endcase
    end

    lld_node_mem #(
        .POOL_NODES (POOL_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_node_mem (
        .i_clk        (i_clk),
        .i_rd_en      (accept),
        .i_rd_addr    (rd_addr),
        .o_rd_value   (rd_value),
        .o_rd_live    (rd_live),
        .o_rd_next    (rd_next),
        .o_rd_prev    (rd_prev),
        .i_we         (we),
        .i_value_addr (value_addr),
        .i_live_addr  (live_addr),
        .i_next_addr  (next_addr),
        .i_prev_addr  (prev_addr),
        .i_value      (r_dv),
        .i_live       (live_wd),
        .i_next       (next_wd),
        .i_prev       (prev_wd)
    );

    lld_free_stack #(
        .POOL_NODES (POOL_NODES)
    ) u_free_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (accept),
        .i_pop      (fs_pop),
        .i_push     (fs_push),
        .i_push_idx (r_tgt),
        .o_idx      (fs_idx),
        .o_top      (fs_top),
        .o_low      (fs_low)
    );

    // request decode, meaningful in the execute cycle
    assign full    = (fs_top == '0);
    assign h_live  = r_h_ok && rd_live;
    assign k_ext   = IW'(fs_idx);
    assign pop_nil = (r_func == FN_POP_FRONT) ? (r_first == NIL) : (r_last == NIL);

    always_comb begin
        exe_status = ST_OK;
        do_alloc   = 1'b0;
        do_unlink  = 1'b0;
        alloc_prev = NIL;
        alloc_next = NIL;
        unique case (r_func) inside
            FN_PUSH_FRONT: begin
                if (full) begin
                    exe_status = ST_FULL;
                end else begin
                    do_alloc   = 1'b1;
                    alloc_next = r_first;
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    exe_status = ST_FULL;
                end else begin
                    do_alloc   = 1'b1;
                    alloc_prev = r_last;
                end
            end
            FN_INSERT_AFTER: begin
                if (!h_live) begin
                    exe_status = ST_DEAD;
                end else if (full) begin
                    exe_status = ST_FULL;
                end else begin
                    do_alloc   = 1'b1;
                    alloc_prev = IW'(r_h);
                    alloc_next = rd_next;
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (pop_nil) begin
                    exe_status = ST_EMPTY;
                end else begin
                    do_unlink = 1'b1;
                end
            end
            FN_REMOVE: begin
                if (!h_live) begin
                    exe_status = ST_DEAD;
                end else begin
                    do_unlink = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // memory writes, pointer updates and sequencing
    always_comb begin
        we          = '0;
        value_addr  = fs_idx;
        live_addr   = fs_idx;
        next_addr   = fs_idx;
        prev_addr   = fs_idx;
        live_wd     = 1'b1;
        next_wd     = alloc_next;
        prev_wd     = alloc_prev;
        fs_pop      = 1'b0;
        fs_push     = 1'b0;
        n_first     = r_first;
        n_last      = r_last;
        n_count     = r_count;
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;

        res_c.status        = exe_status;
        res_c.used_handle   = '0;
        res_c.removed_value = '0;
        res_c.entry_count   = COUNT_W'(r_count);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (do_alloc) begin
                    we.value = 1'b1;
                    we.live  = 1'b1;
                    we.next  = 1'b1;
                    we.prev  = 1'b1;
                    fs_pop   = 1'b1;
                    n_count  = r_count + IW'(1);
                    if (alloc_prev == NIL) begin
                        n_first = k_ext;
                    end
                    if (alloc_next == NIL) begin
                        n_last = k_ext;
                    end
                    res_c.used_handle = HANDLE_W'(fs_idx);
                end else if (do_unlink) begin
                    // bridge the neighbors over the node and free it
                    we.live   = 1'b1;
                    live_addr = r_tgt;
                    live_wd   = 1'b0;
                    fs_push   = 1'b1;
                    n_count   = r_count - IW'(1);
                    next_addr = AW'(rd_prev);
                    next_wd   = rd_next;
                    prev_addr = AW'(rd_next);
                    prev_wd   = rd_prev;
                    if (rd_prev != NIL) begin
                        we.next = 1'b1;
                    end else begin
                        n_first = rd_next;
                    end
                    if (rd_next != NIL) begin
                        we.prev = 1'b1;
                    end else begin
                        n_last = rd_prev;
                    end
                    res_c.used_handle   = HANDLE_W'(r_tgt);
                    res_c.removed_value = DATA_W'(rd_value);
                end
                res_c.entry_count = COUNT_W'(n_count);
                if (do_alloc) begin
                    n_state = S_LINK;
                end else if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = res_c;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_LINK: begin
                // point the neighbors at the new node
                we.next   = (r_lnk_p != NIL);
                next_addr = AW'(r_lnk_p);
                next_wd   = IW'(r_k);
                we.prev   = (r_lnk_q != NIL);
                prev_addr = AW'(r_lnk_q);
                prev_wd   = IW'(r_k);
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= NIL;
            r_last      <= NIL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_last      <= n_last;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_req.func);
            r_dv   <= VALUE_BITS'(i_req.data_value);
            r_h    <= AW'(i_req.node_handle);
            r_h_ok <= in_pool && (IW'(AW'(i_req.node_handle)) >= fs_low);
            r_tgt  <= rd_addr;
        end
        if (r_state == S_EXEC) begin
            r_res   <= res_c;
            r_lnk_p <= alloc_prev;
            r_lnk_q <= alloc_next;
            r_k     <= fs_idx;
        end
        r_out <= n_out;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.used_handle   = r_out.used_handle;
    assign o_rsp.removed_value = r_out.removed_value;
    assign o_rsp.entry_count   = r_out.entry_count;

    `LLD_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, accept, r_state == S_EXEC,
        "accepted word did not enter execute")
    `LLD_ASSERT_NOW(a_pool_balance, i_clk, i_rst_n, r_state == S_IDLE,
        32'(r_count) + 32'(fs_top) == 32'(POOL_NODES), "live plus free nodes off pool size")
    `LLD_ASSERT_NOW(a_ends_empty, i_clk, i_rst_n, r_state == S_IDLE,
        ((r_first == NIL) == (r_count == '0)) && ((r_last == NIL) == (r_count == '0)),
        "list ends disagree with live count")
    `LLD_ASSERT_NOW(a_link_ok, i_clk, i_rst_n, r_state == S_LINK,
        r_res.status == ST_OK, "link writeback after a rejected request")

endmodule
